### hw/rtl/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared widths, character codes, status codes and result types of the
// log field splitter.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int NEST_DEPTH  = 16;
  localparam int MAX_RECORD  = 4096;

  localparam int CHAR_W      = 8;
  localparam int LIMIT_W     = 6;
  localparam int INDEX_W     = 6;
  localparam int POS_W       = $clog2(MAX_RECORD);
  localparam int LEN_W       = POS_W + 1;
  localparam int LEVEL_W     = $clog2(NEST_DEPTH + 1);
  localparam int SLOT_W      = $clog2(NEST_DEPTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] FIELD_LIMIT_RST = LIMIT_W'(10);

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;

  localparam logic KIND_QUOTE   = 1'b1;
  localparam logic KIND_BRACKET = 1'b0;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_MANY  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [INDEX_W-1:0] field_index;
    logic [POS_W-1:0]   field_start;
    logic [LEN_W-1:0]   field_length;
    status_t            status;
    logic               record_done;
  } result_t;

  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } result_pair_t;

endpackage

### hw/rtl/lfs_if.sv
// ----------------------------------------------------------------------------
// lfs_in_if / lfs_out_if
// Valid/ready channels for record bytes and for field results.
// ----------------------------------------------------------------------------
interface lfs_in_if;
  import lfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              end_of_record;

  modport source (output valid, char_byte, end_of_record, input ready);
  modport sink   (input valid, char_byte, end_of_record, output ready);
endinterface

interface lfs_out_if;
  import lfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] field_index;
  logic [POS_W-1:0]   field_start;
  logic [LEN_W-1:0]   field_length;
  logic [1:0]         status;
  logic               record_done;

  modport source (output valid, field_index, field_start, field_length, status,
                  record_done, input ready);
  modport sink   (input valid, field_index, field_start, field_length, status,
                  record_done, output ready);
endinterface

### hw/rtl/lfs_core.sv
// ----------------------------------------------------------------------------
// lfs_core
// Per-byte tokenizer step: nesting stack, field tracking and error checks.
// Produces up to two results for each accepted beat.
// ----------------------------------------------------------------------------
module lfs_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [lfs_pkg::CHAR_W-1:0]   char_byte,
  input  logic                         end_of_record,
  input  logic [lfs_pkg::LIMIT_W-1:0]  field_limit,
  output lfs_pkg::result_pair_t        res
);
  import lfs_pkg::*;

  logic                  stack_r [NEST_DEPTH];
  logic [LEVEL_W-1:0]    level_r,     level_nxt;
  logic [CHAR_W-1:0]     held_r,      held_nxt;
  logic [CHAR_W-1:0]     prior_r,     prior_nxt;
  logic [POS_W-1:0]      pos_r,       pos_nxt;
  logic [POS_W-1:0]      open_r,      open_nxt;
  logic [INDEX_W-1:0]    fe_r,        fe_nxt;
  logic                  held_vld_r,  held_vld_nxt;
  logic                  failed_r,    failed_nxt;

  logic                  stack_we;
  logic [SLOT_W-1:0]     stack_wslot;
  logic                  stack_wkind;

  logic [POS_W-1:0]      pos_h;
  logic [LEVEL_W-1:0]    level_m1;
  logic                  top_kind;
  logic                  is_last;
  logic                  do_push;
  logic                  do_close;
  logic                  kind;
  logic                  fail;
  status_t               fail_code;

  assign pos_h    = pos_r - 1'b1;
  assign level_m1 = level_r - 1'b1;
  assign top_kind = stack_r[level_m1[SLOT_W-1:0]];
  assign is_last  = end_of_record || (pos_r == POS_W'(MAX_RECORD - 1));

  always_comb begin
    level_nxt    = level_r;
    held_nxt     = held_r;
    prior_nxt    = prior_r;
    pos_nxt      = pos_r;
    open_nxt     = open_r;
    fe_nxt       = fe_r;
    held_vld_nxt = held_vld_r;
    failed_nxt   = failed_r;
    stack_we     = 1'b0;
    stack_wslot  = level_r[SLOT_W-1:0];
    stack_wkind  = KIND_BRACKET;
    do_push      = 1'b0;
    do_close     = 1'b0;
    kind         = KIND_BRACKET;
    fail         = 1'b0;
    fail_code    = ST_OK;
    res          = '0;

    if (step && held_vld_r && !failed_r) begin
      unique case (held_r)
        CH_SPACE: begin
          if (level_r == '0) begin
            if (fe_r >= field_limit) begin
              fail      = 1'b1;
              fail_code = ST_TOO_MANY;
            end else begin
              res.v0                 = 1'b1;
              res.r0.field_index     = fe_r;
              res.r0.field_start     = open_r;
              res.r0.field_length    = {1'b0, pos_h - open_r};
              res.r0.status          = ST_OK;
              res.r0.record_done     = 1'b0;
              fe_nxt                 = fe_r + 1'b1;
              open_nxt               = pos_h + 1'b1;
            end
          end
        end
        CH_QUOTE: begin
          kind = KIND_QUOTE;
          if (prior_r == CH_SPACE) begin
            do_push = 1'b1;
          end else if (char_byte == CH_SPACE) begin
            do_close = 1'b1;
          end
        end
        CH_OPEN: begin
          do_push = 1'b1;
        end
        CH_CLOSE: begin
          do_close = 1'b1;
        end
        default: begin
        end
      endcase

      if (do_push) begin
        if (level_r == LEVEL_W'(NEST_DEPTH)) begin
          fail      = 1'b1;
          fail_code = ST_OVERFLOW;
        end else begin
          stack_we    = 1'b1;
          stack_wkind = kind;
          level_nxt   = level_r + 1'b1;
        end
      end

      if (do_close) begin
        if (level_r == '0) begin
          fail      = 1'b1;
          fail_code = ST_UNDERFLOW;
        end else if (top_kind == kind) begin
          level_nxt = level_m1;
        end
      end

      if (fail) begin
        res.v0                 = 1'b1;
        res.r0.field_index     = fe_r;
        res.r0.field_start     = '0;
        res.r0.field_length    = '0;
        res.r0.status          = fail_code;
        res.r0.record_done     = 1'b1;
        failed_nxt             = 1'b1;
      end

      prior_nxt = held_r;
    end

    if (step) begin
      if (is_last) begin
        if (!failed_r && !fail) begin
          res.v1              = 1'b1;
          res.r1.field_index  = fe_nxt;
          res.r1.field_start  = open_nxt;
          res.r1.field_length = {1'b0, pos_r} + 1'b1 - {1'b0, open_nxt};
          res.r1.status       = ST_OK;
          res.r1.record_done  = 1'b1;
        end
        level_nxt    = '0;
        held_nxt     = '0;
        prior_nxt    = CH_SPACE;
        pos_nxt      = '0;
        open_nxt     = '0;
        fe_nxt       = '0;
        held_vld_nxt = 1'b0;
        failed_nxt   = 1'b0;
      end else begin
        held_nxt     = char_byte;
        held_vld_nxt = 1'b1;
        pos_nxt      = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      held_r     <= '0;
      prior_r    <= CH_SPACE;
      pos_r      <= '0;
      open_r     <= '0;
      fe_r       <= '0;
      held_vld_r <= 1'b0;
      failed_r   <= 1'b0;
    end else begin
      level_r    <= level_nxt;
      held_r     <= held_nxt;
      prior_r    <= prior_nxt;
      pos_r      <= pos_nxt;
      open_r     <= open_nxt;
      fe_r       <= fe_nxt;
      held_vld_r <= held_vld_nxt;
      failed_r   <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_r[stack_wslot] <= stack_wkind;
    end
  end

endmodule

### hw/rtl/lfs_result_queue.sv
// ----------------------------------------------------------------------------
// lfs_result_queue
// Small result queue: takes zero, one or two results per cycle and
// presents one result beat per cycle at its head while head_ready is high.
// ----------------------------------------------------------------------------
module lfs_result_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lfs_pkg::result_pair_t  wr,
  output logic                   room,
  output logic                   head_valid,
  output lfs_pkg::result_t       head,
  input  logic                   head_ready
);
  import lfs_pkg::*;

  result_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]    cnt_r,    cnt_nxt;
  logic                 pop;
  logic                 first_v;
  logic                 both_v;
  result_t              first_res;
  logic [QCNT_W-1:0]    n_wr;
  logic [QPTR_W-1:0]    wr_ptr_p1;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room       = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop        = head_valid && head_ready;

  assign first_v    = wr.v0 || wr.v1;
  assign both_v     = wr.v0 && wr.v1;
  assign first_res  = wr.v0 ? wr.r0 : wr.r1;
  assign n_wr       = QCNT_W'(wr.v0) + QCNT_W'(wr.v1);
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_wr[QPTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + n_wr - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (first_v) begin
      mem_r[wr_ptr_r] <= first_res;
    end
    if (both_v) begin
      mem_r[wr_ptr_p1] <= wr.r1;
    end
  end

endmodule

### hw/rtl/log_field_splitter.sv
// ----------------------------------------------------------------------------
// log_field_splitter
// Splits web log records into fields at spaces outside quotes and brackets.
//
// in_ch carries one record byte per beat; end_of_record marks the last byte.
// out_ch carries one field result per beat: index, start offset, length,
// status and record_done on the last result of a record.
// cfg_wr_en / cfg_wr_data load the field limit (reset value 10).
//
// Throughput: one byte per cycle while in_ch.ready is high. A byte is
// classified when the byte after it arrives, so a field closed by a space
// is queued on the beat that follows the space; the final field of a record
// is queued with its last byte. Results wait in a four-entry queue;
// in_ch.ready drops while fewer than two slots are free, which is the only
// input stall. When out_ch stalls, the head result holds and bytes keep
// flowing until in_ch.ready drops. A record that fails reports one error
// beat with record_done set and drops its remaining bytes.
// Reset empties the queue, clears the record state and restores the limit.
// ----------------------------------------------------------------------------
module log_field_splitter (
  input  logic                          clk,
  input  logic                          rst_n,
  lfs_in_if.sink                        in_ch,
  lfs_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [lfs_pkg::LIMIT_W-1:0]   cfg_wr_data
);
  import lfs_pkg::*;

  logic [LIMIT_W-1:0] field_limit_r;
  logic               step;
  logic               q_room;
  result_pair_t       res;
  result_t            head;
  logic               head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_limit_r <= FIELD_LIMIT_RST;
    end else if (cfg_wr_en) begin
      field_limit_r <= cfg_wr_data;
    end
  end

  assign in_ch.ready = q_room;
  assign step        = in_ch.valid && q_room;

  lfs_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .char_byte     (in_ch.char_byte),
    .end_of_record (in_ch.end_of_record),
    .field_limit   (field_limit_r),
    .res           (res)
  );

  lfs_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (res),
    .room       (q_room),
    .head_valid (head_valid),
    .head       (head),
    .head_ready (out_ch.ready)
  );

  assign out_ch.valid        = head_valid;
  assign out_ch.field_index  = head.field_index;
  assign out_ch.field_start  = head.field_start;
  assign out_ch.field_length = head.field_length;
  assign out_ch.status       = head.status;
  assign out_ch.record_done  = head.record_done;

endmodule

### hw/rtl/lfs_checker.sv
// ----------------------------------------------------------------------------
// lfs_checker
// Port-level checks of the log field splitter, bound to the top level.
// ----------------------------------------------------------------------------
module lfs_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [lfs_pkg::POS_W-1:0]     field_start,
  input  logic [lfs_pkg::LEN_W-1:0]     field_length,
  input  logic [1:0]                    status,
  input  logic                          record_done
);
  import lfs_pkg::*;

  a_err_beat_shape : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |->
      record_done && (field_start == '0) && (field_length == '0))
    else $error("error beat with nonzero span or without record_done");

  a_mid_beat_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !record_done |-> (status == ST_OK))
    else $error("non-final beat carries an error status");

  a_stall_has_backlog : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(field_start) && $stable(field_length) && $stable(status))
    else $error("stalled result beat changed");

endmodule

bind log_field_splitter lfs_checker u_lfs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .field_start  (out_ch.field_start),
  .field_length (out_ch.field_length),
  .status       (out_ch.status),
  .record_done  (out_ch.record_done)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: log field splitter testbench
// Streams log records byte by byte into the splitter and checks every field
// result against a cycle-free model of the nesting stack and field counter.
// Directed records cover quotes, brackets, empty fields, underflow, overflow,
// the field limit and overlong records; random records follow, mostly
// well-formed log lines with some noise and damaged bytes. The sender idles in
// bursts, the receiver stalls on its own pattern and once holds off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import lfs_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;

  lfs_in_if  in_ch ();
  lfs_out_if out_ch ();

  log_field_splitter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // model of the splitter state
  logic               nest_kind [NEST_DEPTH];
  int                 nest_level;
  logic [CHAR_W-1:0]  held_char;
  logic [CHAR_W-1:0]  prev_char;
  int                 next_pos;
  int                 field_open;
  int                 emitted_count;
  bit                 held_present;
  bit                 record_dead;
  logic [LIMIT_W-1:0] limit_now;

  result_t            field_results_due [$];
  logic [CHAR_W-1:0]  record_bytes [$];

  int mismatch_count;
  int results_seen;
  int burst_left;
  int idle_gap;
  bit byte_offered;
  int rx_hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  function automatic void log_field_result(input int idx, input int start, input int len,
                                           input status_t st, input logic done);
    result_t r;
    r.field_index  = INDEX_W'(idx);
    r.field_start  = POS_W'(start);
    r.field_length = LEN_W'(len);
    r.status       = st;
    r.record_done  = done;
    field_results_due.insert(field_results_due.size(), r);
  endfunction

  function automatic void clear_record();
    nest_level    = 0;
    held_char     = '0;
    prev_char     = CH_SPACE;
    next_pos      = 0;
    field_open    = 0;
    emitted_count = 0;
    held_present  = 1'b0;
    record_dead   = 1'b0;
  endfunction

  function automatic void fail_record(input status_t st);
    log_field_result(emitted_count, 0, 0, st, 1'b1);
    record_dead = 1'b1;
  endfunction

  function automatic void push_nest(input logic kind);
    if (nest_level >= NEST_DEPTH) begin
      fail_record(ST_OVERFLOW);
    end else begin
      nest_kind[nest_level] = kind;
      nest_level++;
    end
  endfunction

  function automatic void pop_nest(input logic kind);
    if (nest_level == 0) begin
      fail_record(ST_UNDERFLOW);
    end else if (nest_kind[nest_level-1] == kind) begin
      nest_level--;
    end
  endfunction

  function automatic void classify_held(input logic [CHAR_W-1:0] following);
    int pos;
    pos = next_pos - 1;
    if (held_char == CH_SPACE) begin
      if (nest_level == 0) begin
        if (emitted_count >= int'(limit_now)) begin
          fail_record(ST_TOO_MANY);
        end else begin
          log_field_result(emitted_count, field_open, pos - field_open, ST_OK, 1'b0);
          emitted_count++;
          field_open = pos + 1;
        end
      end
    end else if (held_char == CH_QUOTE) begin
      if (prev_char == CH_SPACE) begin
        push_nest(KIND_QUOTE);
      end else if (following == CH_SPACE) begin
        pop_nest(KIND_QUOTE);
      end
    end else if (held_char == CH_OPEN) begin
      push_nest(KIND_BRACKET);
    end else if (held_char == CH_CLOSE) begin
      pop_nest(KIND_BRACKET);
    end
    prev_char = held_char;
  endfunction

  function automatic void track_record_byte(input logic [CHAR_W-1:0] c, input logic eor);
    int pos;
    bit closing;
    pos     = next_pos;
    closing = eor || (pos >= MAX_RECORD - 1);
    if (!record_dead && held_present) begin
      classify_held(c);
    end
    if (closing) begin
      if (!record_dead) begin
        log_field_result(emitted_count, field_open, pos + 1 - field_open, ST_OK, 1'b1);
      end
      clear_record();
    end else begin
      held_char    = c;
      held_present = 1'b1;
      next_pos     = pos + 1;
    end
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eor);
    repeat (idle_gap) @(posedge clk);
    idle_gap = 0;
    in_ch.valid         <= 1'b1;
    in_ch.char_byte     <= c;
    in_ch.end_of_record <= eor;
    byte_offered = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    track_record_byte(c, eor);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle_gap != 0) begin
        in_ch.valid <= 1'b0;
        byte_offered = 1'b0;
      end
    end
  endtask

  task automatic send_record(input bit close_it);
    int n;
    n = record_bytes.size();
    for (int i = 0; i < n; i++) begin
      send_byte(record_bytes[i], close_it && (i == n - 1));
    end
    record_bytes.delete();
  endtask

  function automatic void put_byte(input logic [CHAR_W-1:0] c);
    record_bytes.insert(record_bytes.size(), c);
  endfunction

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(s[i]);
    end
  endfunction

  function automatic void append_run(input logic [CHAR_W-1:0] c, input int n);
    repeat (n) put_byte(c);
  endfunction

  task automatic send_text(input string s);
    record_bytes.delete();
    append_text(s);
    send_record(1'b1);
  endtask

  // drop valid, drain expected results, then let the pipeline go quiet
  task automatic settle_block();
    int waited;
    if (byte_offered) begin
      in_ch.valid <= 1'b0;
      byte_offered = 1'b0;
    end
    waited = 0;
    while (field_results_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic load_field_limit(input logic [LIMIT_W-1:0] v);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    limit_now = v;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] special_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_QUOTE;
      2:       return CH_OPEN;
      default: return CH_CLOSE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) begin
        c = CHAR_W'($urandom_range(0, 255));
      end else begin
        c = CHAR_W'($urandom_range(33, 126));
      end
    end while (c == CH_SPACE || c == CH_QUOTE || c == CH_OPEN || c == CH_CLOSE);
    return c;
  endfunction

  function automatic void add_word();
    repeat ($urandom_range(1, 10)) put_byte(plain_char());
  endfunction

  function automatic void add_quoted();
    int words;
    words = $urandom_range(1, 3);
    put_byte(CH_QUOTE);
    for (int w = 0; w < words; w++) begin
      if (w != 0) begin
        put_byte(CH_SPACE);
      end
      add_word();
    end
    put_byte(CH_QUOTE);
  endfunction

  function automatic void add_bracketed(input int depth);
    int items;
    items = $urandom_range(1, 3);
    put_byte(CH_OPEN);
    for (int w = 0; w < items; w++) begin
      if (w != 0) begin
        put_byte(CH_SPACE);
      end
      if (depth == 0 && $urandom_range(0, 4) == 0) begin
        add_bracketed(depth + 1);
      end else begin
        add_word();
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      put_byte(CH_SPACE);
      add_quoted();
      put_byte(CH_SPACE);
      add_word();
    end
    put_byte(CH_CLOSE);
  endfunction

  function automatic void build_log_record();
    int roll;
    int lim;
    int cap;
    int n_fields;
    int k;
    record_bytes.delete();
    roll = $urandom_range(0, 99);
    lim  = int'(limit_now);
    if (roll < 10) begin
      k = $urandom_range(1, 24);
      repeat (k) begin
        put_byte(($urandom_range(0, 1) == 0) ? special_char() :
                 CHAR_W'($urandom_range(0, 255)));
      end
      return;
    end
    if (roll < 15) begin
      append_run(CH_OPEN, $urandom_range(NEST_DEPTH - 2, NEST_DEPTH + 2));
      add_word();
      append_text(" x");
      return;
    end
    cap      = (lim + 1 < 8) ? lim + 1 : 8;
    n_fields = ($urandom_range(0, 9) == 0) ? lim + $urandom_range(0, 3) :
               $urandom_range(1, cap);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) begin
        put_byte(CH_SPACE);
        if ($urandom_range(0, 19) == 0) begin
          put_byte(CH_SPACE);
        end
      end
      k = $urandom_range(0, 9);
      if (k < 6) begin
        add_word();
      end else if (k < 8) begin
        add_quoted();
      end else begin
        add_bracketed(0);
      end
    end
    if (roll < 27) begin
      record_bytes[$urandom_range(0, record_bytes.size() - 1)] = special_char();
    end
  endfunction

  task automatic run_random_records(input int byte_budget);
    int sent;
    sent = 0;
    while (sent < byte_budget) begin
      build_log_record();
      sent += record_bytes.size();
      send_record(1'b1);
    end
  endtask

  task automatic test_plain_fields();
    send_text("GET /index.html 200");
    send_text("x");
    send_text("a ");
    send_text(" a");
    send_text("a  b");
    send_text("  ");
  endtask

  task automatic test_quotes();
    send_text("\"a b\" c");
    send_text("x \"q r\" y");
    send_text("ab\" c d");
    send_text("a\"b c");
    send_text("\"open x y");
  endtask

  task automatic test_brackets();
    send_text("[a b] c");
    send_text("] x y");
    send_text("[a \"b] c\" d] e");
    send_text("p [q [r s] t] u");
  endtask

  task automatic test_nesting_depth();
    record_bytes.delete();
    append_run(CH_OPEN, NEST_DEPTH);
    append_text("a b");
    append_run(CH_CLOSE, NEST_DEPTH);
    append_text(" c");
    send_record(1'b1);
    append_run(CH_OPEN, NEST_DEPTH + 1);
    append_text(" z w");
    send_record(1'b1);
  endtask

  task automatic test_field_limit();
    load_field_limit(LIMIT_W'(1));
    send_text("a b");
    send_text("a b c d");
    load_field_limit(LIMIT_W'(2));
    send_text("a b c");
    send_text("a b c d");
  endtask

  task automatic test_overlong_record();
    load_field_limit(LIMIT_W'(63));
    record_bytes.delete();
    append_run("x", 4000);
    put_byte(CH_SPACE);
    append_run("y", MAX_RECORD - 4001);
    send_record(1'b0);
    send_text("n");
    record_bytes.delete();
    append_run("w", MAX_RECORD);
    send_record(1'b0);
    send_text("m o");
  endtask

  task automatic test_output_hold_off();
    settle_block();
    rx_hold_request = 300;
    record_bytes.delete();
    repeat (39) append_text("ab ");
    append_text("ab");
    send_record(1'b1);
  endtask

  task automatic test_random_traffic();
    load_field_limit(LIMIT_W'($urandom_range(2, 12)));
    run_random_records(400);
    load_field_limit(LIMIT_W'(1));
    run_random_records(200);
    load_field_limit(LIMIT_W'(63));
    run_random_records(400);
    load_field_limit(LIMIT_W'($urandom_range(1, 63)));
    run_random_records(300);
  endtask

  // receiver: random stall modes, plus long hold-offs on request
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    out_ch.ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (rx_hold_request != 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ((tick % 5) < 2);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (field_results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d unexpected: index %0d status %0d",
                                  results_seen, out_ch.field_index, out_ch.status));
      end else begin
        want = field_results_due.pop_front();
        if (out_ch.field_index !== want.field_index) begin
          report_mismatch($sformatf("result %0d field_index got %0d want %0d",
                                    results_seen, out_ch.field_index, want.field_index));
        end
        if (out_ch.field_start !== want.field_start) begin
          report_mismatch($sformatf("result %0d field_start got %0d want %0d",
                                    results_seen, out_ch.field_start, want.field_start));
        end
        if (out_ch.field_length !== want.field_length) begin
          report_mismatch($sformatf("result %0d field_length got %0d want %0d",
                                    results_seen, out_ch.field_length, want.field_length));
        end
        if (out_ch.status !== want.status) begin
          report_mismatch($sformatf("result %0d status got %0d want %0d",
                                    results_seen, out_ch.status, want.status));
        end
        if (out_ch.record_done !== want.record_done) begin
          report_mismatch($sformatf("result %0d record_done got %0b want %0b",
                                    results_seen, out_ch.record_done, want.record_done));
        end
      end
      results_seen++;
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.char_byte     = '0;
    in_ch.end_of_record = 1'b0;
    mismatch_count      = 0;
    results_seen        = 0;
    burst_left          = 0;
    idle_gap            = 0;
    byte_offered        = 1'b0;
    rx_hold_request     = 0;
    limit_now           = FIELD_LIMIT_RST;
    clear_record();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_fields();
    test_quotes();
    test_brackets();
    test_nesting_depth();
    test_field_limit();
    test_overlong_record();
    test_output_hold_off();
    test_random_traffic();

    settle_block();
    if (field_results_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                field_results_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/lfs_pkg.sv
hw/rtl/lfs_if.sv
hw/rtl/lfs_core.sv
hw/rtl/lfs_result_queue.sv
hw/rtl/log_field_splitter.sv
hw/rtl/lfs_checker.sv
dv/tb_top.sv
